FILE: src/utf8_permissive_decoder_defines.svh
// Assertion macros shared by the checker of the UTF-8 decoder.
`ifndef UTF8_PERMISSIVE_DECODER_DEFINES_SVH
`define UTF8_PERMISSIVE_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define U8PD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("u8pd check failed");

// Next-cycle implication, disabled while reset is low.
`define U8PD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("u8pd check failed");

`endif

FILE: src/u8pd_pkg.sv
package u8pd_pkg;

    localparam int unsigned CpW = 21;
    localparam int unsigned JobSlots = 4;

    // Lead classes: continuation count of a byte taken as a lead.
    localparam logic [2:0] CLS_ASCII   = 3'd0;
    localparam logic [2:0] CLS_TWO     = 3'd1;
    localparam logic [2:0] CLS_THREE   = 3'd2;
    localparam logic [2:0] CLS_FOUR    = 3'd3;
    localparam logic [2:0] CLS_INVALID = 3'd4;

    localparam logic [7:0] CONT_MARK = 8'h80;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } t_in_beat;

    typedef struct packed {
        logic [CpW-1:0] code_point;
        logic           raw_fallback;
        logic           run_last;
    } t_out_beat;

    typedef struct packed {
        logic [CpW-1:0] code_point;
        logic           raw_fallback;
    } t_res;

    // One queued job: every result caused by one input byte.
    typedef struct packed {
        logic [1:0]               last_idx;
        t_res [JobSlots-1:0]      slots;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [2:0] lead_class(input logic [7:0] b);
        logic [2:0] cls;
        if (b[7] == 1'b0) begin
            cls = CLS_ASCII;
        end else if (b[7:5] == 3'b110) begin
            cls = CLS_TWO;
        end else if (b[7:4] == 4'b1110) begin
            cls = CLS_THREE;
        end else if (b[7:3] == 5'b11110) begin
            cls = CLS_FOUR;
        end else begin
            cls = CLS_INVALID;
        end
        return cls;
    endfunction

    function automatic t_res raw_res(input logic [7:0] b);
        t_res r;
        r.code_point   = {{(CpW-8){1'b0}}, b};
        r.raw_fallback = 1'b1;
        return r;
    endfunction

endpackage

FILE: src/u8pd_front.sv
module u8pd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  u8pd_pkg::t_in_beat i_data,
    input  u8pd_pkg::t_q_stat  i_q_stat,
    output logic              o_push,
    output u8pd_pkg::t_job    o_job
);

    logic [7:0] r_lead, n_lead;
    logic [5:0] r_cont [2];
    logic [1:0] r_need, n_need;
    logic [1:0] r_held, n_held;

    logic        accept;
    logic [7:0]  b;
    logic        eot;
    logic [2:0]  k;
    logic [2:0]  cls;
    logic        wr_cont;
    u8pd_pkg::t_job job;

    assign o_stall = i_q_stat.full;
    assign accept  = i_valid && !i_q_stat.full;
    assign b       = i_data.in_byte;
    assign eot     = i_data.end_of_text;
    assign cls     = u8pd_pkg::lead_class(b);

    always_comb begin
        k       = 3'd0;
        job     = '0;
        n_lead  = r_lead;
        n_need  = r_need;
        n_held  = r_held;
        wr_cont = 1'b0;
        if (r_need != 2'd0 && b[7:6] == 2'b10) begin
            if ({1'b0, r_held} + 3'd1 >= {1'b0, r_need}) begin
                // complete the sequence
                job.slots[0].raw_fallback = 1'b0;
                case (r_need)
                    2'd1:    job.slots[0].code_point = {10'd0, r_lead[4:0], b[5:0]};
                    2'd2:    job.slots[0].code_point =
                                 {5'd0, r_lead[3:0], r_cont[0], b[5:0]};
                    default: job.slots[0].code_point =
                                 {r_lead[2:0], r_cont[0], r_cont[1], b[5:0]};
                endcase
                k      = 3'd1;
                n_need = 2'd0;
                n_held = 2'd0;
            end else if (eot) begin
                job.slots[0] = u8pd_pkg::raw_res(r_lead);
                job.slots[1] = u8pd_pkg::raw_res(u8pd_pkg::CONT_MARK | {2'b00, r_cont[0]});
                job.slots[2] = u8pd_pkg::raw_res(u8pd_pkg::CONT_MARK | {2'b00, r_cont[1]});
                k = 3'd1 + {1'b0, r_held};
                job.slots[k[1:0]] = u8pd_pkg::raw_res(b);
                k      = k + 3'd1;
                n_need = 2'd0;
                n_held = 2'd0;
            end else begin
                wr_cont = 1'b1;
                n_held  = r_held + 2'd1;
            end
        end else begin
            if (r_need != 2'd0) begin
                // broken sequence: drop it out raw before the new byte
                job.slots[0] = u8pd_pkg::raw_res(r_lead);
                job.slots[1] = u8pd_pkg::raw_res(u8pd_pkg::CONT_MARK | {2'b00, r_cont[0]});
                job.slots[2] = u8pd_pkg::raw_res(u8pd_pkg::CONT_MARK | {2'b00, r_cont[1]});
                k      = 3'd1 + {1'b0, r_held};
                n_need = 2'd0;
                n_held = 2'd0;
            end
            if (cls == u8pd_pkg::CLS_ASCII) begin
                job.slots[k[1:0]].code_point   = {13'd0, b};
                job.slots[k[1:0]].raw_fallback = 1'b0;
                k = k + 3'd1;
            end else if (cls == u8pd_pkg::CLS_INVALID || eot) begin
                job.slots[k[1:0]] = u8pd_pkg::raw_res(b);
                k = k + 3'd1;
            end else begin
                n_lead = b;
                n_need = cls[1:0];
                n_held = 2'd0;
            end
        end
        job.last_idx = k[1:0] - 2'd1;
    end

    assign o_push = accept && (k != 3'd0);
    assign o_job  = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead <= '0;
            r_need <= '0;
            r_held <= '0;
        end else if (accept) begin
            r_lead <= n_lead;
            r_need <= n_need;
            r_held <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && wr_cont) begin
            r_cont[r_held[0]] <= b[5:0];
        end
    end

endmodule

FILE: src/u8pd_fifo.sv
module u8pd_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  u8pd_pkg::t_job    i_job,
    input  logic              i_pop,
    output u8pd_pkg::t_job    o_head,
    output u8pd_pkg::t_q_stat o_stat
);

    u8pd_pkg::t_job r_mem [2];
    logic           r_wr, r_rd;
    logic [1:0]     r_cnt;

    assign o_head       = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == 2'd2);
    assign o_stat.empty = (r_cnt == 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

FILE: src/u8pd_back.sv
module u8pd_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  u8pd_pkg::t_job     i_head,
    input  u8pd_pkg::t_q_stat  i_q_stat,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output u8pd_pkg::t_out_beat o_data
);

    logic                r_valid;
    u8pd_pkg::t_out_beat r_data, n_data;
    logic [1:0]          r_idx;
    logic                load;
    logic                last;

    assign load = !i_q_stat.empty && (!r_valid || !i_stall);
    assign last = (r_idx == i_head.last_idx);
    assign o_pop = load && last;

    always_comb begin
        n_data.code_point   = i_head.slots[r_idx].code_point;
        n_data.raw_fallback = i_head.slots[r_idx].raw_fallback;
        n_data.run_last     = last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= last ? 2'd0 : r_idx + 2'd1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: src/utf8_permissive_decoder.sv
// Permissive UTF-8 decoder. Feed one text byte per beat on i_data, with
// end_of_text set on the final byte; each o_data beat carries one code point
// (up to 21 bits) or, with raw_fallback set, one byte passed through as is.
// No overlong, surrogate or range checks are made. A broken or unfinished
// sequence is undone: its lead byte and held continuation bytes come out raw
// in order, and the breaking byte is then decoded afresh; stray continuation
// bytes and 0xF8-0xFF come out raw. run_last marks the last result caused by
// an input byte. Input bytes that open a sequence or add a continuation give
// no result. Rate: one byte per cycle in, one result per cycle out while
// i_stall is low; a byte that causes n results (n is 1 to 4) takes n output
// beats, and the two-entry job queue between the classifier and the output
// sequencer absorbs those runs, so input stalls only when the queue is full.
// A byte's first result passes through the job queue and the output register.
module utf8_permissive_decoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  u8pd_pkg::t_in_beat  i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output u8pd_pkg::t_out_beat o_data
);

    u8pd_pkg::t_q_stat q_stat;
    u8pd_pkg::t_job    push_job;
    u8pd_pkg::t_job    head_job;
    logic              push;
    logic              pop;

    // Classify each byte and track the open sequence; emit a job per byte that causes results.
    u8pd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_data   (i_data),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_job    (push_job)
    );

    // Hold pending jobs so front and back stall independently.
    u8pd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_head  (head_job),
        .o_stat  (q_stat)
    );

    // Advance through the head job one result beat per cycle while i_stall is low.
    u8pd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head_job),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_data   (o_data)
    );

endmodule

FILE: src/u8pd_checker.sv
`include "utf8_permissive_decoder_defines.svh"

module u8pd_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  u8pd_pkg::t_out_beat i_out_data
);

    logic out_raw;
    logic out_busy;
    logic out_decoded;
    logic raw_byte_ok;

    assign out_raw     = i_out_valid && i_out_data.raw_fallback;
    assign out_busy    = i_out_valid && i_out_stall;
    assign out_decoded = i_out_valid && !i_out_data.raw_fallback;
    // A raw beat is always one byte with the top bit set.
    assign raw_byte_ok = (i_out_data.code_point[20:8] == 13'd0) && i_out_data.code_point[7];

    `U8PD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_busy, i_out_valid && $stable(i_out_data))
    `U8PD_ASSERT_NOW(a_raw_is_high_byte, i_clk, i_rst_n, out_raw, raw_byte_ok)
    `U8PD_ASSERT_NOW(a_decoded_ends_run, i_clk, i_rst_n, out_decoded, i_out_data.run_last)
    `U8PD_ASSERT_NOW(a_in_stall_known, i_clk, i_rst_n, i_in_valid, !$isunknown(i_in_stall))

endmodule

bind utf8_permissive_decoder u8pd_checker u_u8pd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_valid),
    .i_in_stall  (o_stall),
    .i_out_valid (o_valid),
    .i_out_stall (i_stall),
    .i_out_data  (o_data)
);

FILE: test/utf8_permissive_decoder_tb.sv
`timescale 1ns / 100ps

module utf8_permissive_decoder_tb;

    // Cycles with no beat on either channel before the run is declared hung.
    // The worst correct stretch is a sender gap plus a receiver stall plus the
    // decoder's own latency, so this leaves a wide margin.
    localparam int unsigned HangLimit = 2000;
    // Cycles to watch the output after the last awaited code point arrives.
    localparam int unsigned TailCycles = 16;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    u8pd_pkg::t_in_beat  i_data = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    u8pd_pkg::t_out_beat o_data;

    utf8_permissive_decoder u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    always #4 i_clk = ~i_clk;

    // Predictor state: the open sequence as the decoder should hold it.
    logic [7:0] open_lead = 8'd0;
    logic [5:0] held_payload [2];
    logic [1:0] conts_needed = 2'd0;
    logic [1:0] conts_held = 2'd0;

    // Code points still owed by the decoder, oldest first.
    u8pd_pkg::t_out_beat awaited_points [$];
    // Results of the byte being decoded right now.
    u8pd_pkg::t_out_beat byte_results [$];

    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles = 0;
    // Set for a stretch of back-to-back traffic with no idling on either side.
    bit          no_idle = 1'b0;
    u8pd_pkg::t_out_beat want;

    function automatic logic [2:0] lead_kind(input logic [7:0] b);
        if ((b & 8'h80) == 8'h00) return u8pd_pkg::CLS_ASCII;
        if ((b & 8'hE0) == 8'hC0) return u8pd_pkg::CLS_TWO;
        if ((b & 8'hF0) == 8'hE0) return u8pd_pkg::CLS_THREE;
        if ((b & 8'hF8) == 8'hF0) return u8pd_pkg::CLS_FOUR;
        return u8pd_pkg::CLS_INVALID;
    endfunction

    function automatic void emit(input logic [31:0] cp, input logic raw);
        u8pd_pkg::t_out_beat r;
        r.code_point   = cp[u8pd_pkg::CpW-1:0];
        r.raw_fallback = raw;
        r.run_last     = 1'b0;
        byte_results = {byte_results, r};
    endfunction

    // Undo the open sequence: lead first, then each held continuation.
    function automatic void flush_open();
        emit({24'd0, open_lead}, 1'b1);
        for (int j = 0; j < int'(conts_held) && j < 2; j++) begin
            emit({24'd0, 2'b10, held_payload[j]}, 1'b1);
        end
        conts_needed = 2'd0;
        conts_held   = 2'd0;
    endfunction

    // Decode a byte with no sequence open.
    function automatic void decode_fresh(input logic [7:0] b, input logic eot);
        logic [2:0] kind;
        kind = lead_kind(b);
        if (kind == u8pd_pkg::CLS_ASCII) begin
            emit({24'd0, b}, 1'b0);
        end else if (kind == u8pd_pkg::CLS_INVALID || eot) begin
            emit({24'd0, b}, 1'b1);
        end else begin
            open_lead    = b;
            conts_needed = kind[1:0];
            conts_held   = 2'd0;
        end
    endfunction

    // Work out every code point one accepted byte causes and queue them.
    function automatic void decode_byte(input u8pd_pkg::t_in_beat beat);
        logic [7:0]  b;
        logic        eot;
        logic [31:0] acc;
        b   = beat.in_byte;
        eot = beat.end_of_text;
        byte_results.delete();
        if (conts_needed != 2'd0) begin
            if (b[7:6] == 2'b10) begin
                if (int'(conts_held) + 1 >= int'(conts_needed)) begin
                    case (conts_needed)
                        2'd1:    acc = {24'd0, open_lead & 8'h1F};
                        2'd2:    acc = {24'd0, open_lead & 8'h0F};
                        default: acc = {24'd0, open_lead & 8'h07};
                    endcase
                    for (int j = 0; j < int'(conts_held) && j < 2; j++) begin
                        acc = (acc << 6) | {26'd0, held_payload[j]};
                    end
                    acc = (acc << 6) | {26'd0, b[5:0]};
                    emit(acc, 1'b0);
                    conts_needed = 2'd0;
                    conts_held   = 2'd0;
                end else if (eot) begin
                    // Early end: undo the sequence, then pass this byte raw.
                    flush_open();
                    emit({24'd0, b}, 1'b1);
                end else begin
                    held_payload[conts_held[0]] = b[5:0];
                    conts_held = conts_held + 2'd1;
                end
            end else begin
                // Broken sequence: undo it and decode the byte afresh.
                flush_open();
                decode_fresh(b, eot);
            end
        end else begin
            decode_fresh(b, eot);
        end
        if (byte_results.size() > 0) begin
            byte_results[byte_results.size() - 1].run_last = 1'b1;
        end
        foreach (byte_results[k]) awaited_points = {awaited_points, byte_results[k]};
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned exp_val);
        mismatch_count++;
        $display("mismatch: %s got 0x%0h want 0x%0h", what, got, exp_val);
    endtask

    function automatic int unsigned idle_cycles();
        if (no_idle) return 0;
        // Favor zero so that stretches of back-to-back beats show up too.
        if ($urandom_range(0, 3) == 0) return 0;
        return $urandom_range(0, 14);
    endfunction

    // Predict on accepted input beats and check accepted output beats. Run
    // the prediction first so that ordering within this process is fixed.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                decode_byte(i_data);
            end
            if (o_valid && !i_stall) begin
                if (awaited_points.size() == 0) begin
                    report_mismatch("unexpected code point", o_data.code_point, 0);
                end else begin
                    want = awaited_points.pop_front();
                    if (o_data.code_point !== want.code_point)
                        report_mismatch("code_point", o_data.code_point, want.code_point);
                    if (o_data.raw_fallback !== want.raw_fallback)
                        report_mismatch("raw_fallback", o_data.raw_fallback,
                                        want.raw_fallback);
                    if (o_data.run_last !== want.run_last)
                        report_mismatch("run_last", o_data.run_last, want.run_last);
                end
            end
        end
    end

    // Hang watchdog: count cycles with no beat on either channel.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= HangLimit) begin
            $display("utf8_permissive_decoder verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Receiver: before each result beat, hold stall for a random count.
    initial begin
        int unsigned hold;
        forever begin
            hold = idle_cycles();
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
                i_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!(o_valid && i_rst_n));
        end
    end

    // Send one byte beat after a random gap; return at the edge it is taken.
    // Keep valid high across back-to-back beats instead of toggling it.
    task automatic send_byte(input logic [7:0] b, input logic eot);
        int unsigned        gap;
        u8pd_pkg::t_in_beat beat;
        gap = idle_cycles();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        beat.in_byte     = b;
        beat.end_of_text = eot;
        i_valid <= 1'b1;
        i_data  <= beat;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Drop valid and wait until every awaited code point has come out.
    task automatic hold_until_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (awaited_points.size() != 0) @(posedge i_clk);
    endtask

    // ASCII extremes and one complete sequence of every length, the last one
    // decoding to the largest 21-bit value and closing the text.
    task automatic test_code_point_forms();
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hC2, 1'b0);
        send_byte(8'hA9, 1'b0);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'hAC, 1'b0);
        send_byte(8'hF7, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b1);
    endtask

    task automatic test_special_cases();
        // Stray continuation bytes, lowest and highest.
        send_byte(8'h80, 1'b0);
        send_byte(8'hBF, 1'b0);
        // Invalid leads with no sequence open.
        send_byte(8'hF8, 1'b0);
        send_byte(8'hFF, 1'b0);
        // Invalid lead breaking a four-byte form with two held: four results.
        send_byte(8'hF0, 1'b0);
        send_byte(8'h90, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b0);
        // Text ends one continuation short of a four-byte form.
        send_byte(8'hF0, 1'b0);
        send_byte(8'h90, 1'b0);
        send_byte(8'h80, 1'b1);
        // Lead byte that closes the text.
        send_byte(8'hC3, 1'b1);
        // Open sequence broken by a lead that also closes the text.
        send_byte(8'hD0, 1'b0);
        send_byte(8'hE1, 1'b1);
    endtask

    task automatic send_text_byte(input logic [7:0] b);
        send_byte(b, $urandom_range(0, 11) == 0);
    endtask

    // Mostly well-formed sequences with random payload; some cut short so the
    // next byte breaks them, some pure noise bytes.
    task automatic test_random_text(input int unsigned n_bytes);
        int unsigned sent;
        int unsigned pick;
        int unsigned need;
        int unsigned conts;
        logic [7:0]  lead;
        sent = 0;
        while (sent < n_bytes) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                send_text_byte(8'($urandom_range(0, 127)));
                sent++;
            end else if (pick < 90) begin
                need = $urandom_range(1, 3);
                case (need)
                    1:       lead = 8'hC0 | 8'($urandom_range(0, 31));
                    2:       lead = 8'hE0 | 8'($urandom_range(0, 15));
                    default: lead = 8'hF0 | 8'($urandom_range(0, 7));
                endcase
                conts = (pick < 78) ? need : $urandom_range(0, need - 1);
                send_text_byte(lead);
                for (int k = 0; k < int'(conts); k++) begin
                    send_text_byte(8'h80 | 8'($urandom_range(0, 63)));
                end
                sent += 1 + conts;
            end else begin
                send_text_byte(8'($urandom_range(0, 255)));
                sent++;
            end
        end
    endtask

    task automatic test_back_to_back(input int unsigned n_bytes);
        no_idle = 1'b1;
        test_random_text(n_bytes);
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_code_point_forms();
        test_special_cases();
        hold_until_drained();
        test_random_text(275);
        hold_until_drained();
        test_back_to_back(70);
        hold_until_drained();
        // Watch a while longer for stray results after the last one.
        repeat (TailCycles) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("utf8_permissive_decoder verification clean");
        end else begin
            $display("utf8_permissive_decoder verification failed");
        end
        $finish;
    end

endmodule
